### rtl/core/shifting_array_insert_delete_macros.svh
// Assertion macros used by the port checker of the list block.
// Needs nothing else; include it by its bare file name.
`ifndef SHIFTING_ARRAY_INSERT_DELETE_MACROS_SVH
`define SHIFTING_ARRAY_INSERT_DELETE_MACROS_SVH

// Concurrent check that is switched off while reset is active.
`define SAI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is active.
`define SAI_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sai_pkg.sv
// Types and constants of the shifting list block.
// Used by the top level and the port checker.
package sai_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BADINDEX = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam int         CAP_W     = 5;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         index;
    logic signed [31:0] data;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [5:0]         position;
    logic [6:0]         count;
    logic               last;
  } res_t;

endpackage

### rtl/core/sai_ram.sv
// Element memory of the shifting list: one write port, one registered read port.
// Depends on nothing but its parameters.
module sai_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic signed [31:0]  wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic signed [31:0]  rdata_o
);

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/shifting_array_insert_delete.sv
// Dense list of signed words with insert, update, delete and read-all.
// Update, read of an empty list and every rejected item give their result in the cycle
// after start; insert and delete move one entry at a time, reading it and then writing
// it one place over, before a final step; read-all reads and then emits each element.
// Reset clears the count and sets the capacity to 16; the receiver cannot stall results.
// Depends on sai_pkg and sai_ram.
module shifting_array_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  sai_pkg::req_t             req_i,
  output logic                      busy_o,
  output logic                      res_valid_o,
  output sai_pkg::res_t             res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sai_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHRD = 3'd1;
  localparam logic [2:0] S_SHWR = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_RDRD = 3'd4;
  localparam logic [2:0] S_RDEM = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             ptr_q, ptr_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [1:0]                func_q, func_d;
  logic signed [31:0]        data_q, data_d;
  logic [sai_pkg::CAP_W-1:0] cap_q, cap_d;
  sai_pkg::res_t             res_q, res_d;
  logic                      res_valid_q, res_valid_d;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [31:0]        wdata;
  logic [CW-1:0]             rd_ptr;
  logic signed [31:0]        rdata;

  logic [7:0]                cnt8;
  logic                      fits;
  logic                      full;
  logic [CW-1:0]             ins_idx;
  logic [CW-1:0]             ptr_inc;
  logic [CW-1:0]             ptr_dec;
  logic                      is_ins;

  assign cnt8    = 8'(cnt_q);
  assign fits    = req_i.index < cnt8;
  assign full    = (cnt8 >= 8'(cap_q)) || (cnt_q == CW'(DEPTH));
  assign ins_idx = fits ? CW'(req_i.index) : cnt_q;
  assign ptr_inc = ptr_q + 1'b1;
  assign ptr_dec = ptr_q - 1'b1;
  assign is_ins  = (func_q == sai_pkg::OP_INSERT);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    func_d      = func_q;
    data_d      = data_q;
    cap_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : cap_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    we          = 1'b0;
    waddr       = ptr_q[AW-1:0];
    wdata       = data_q;
    rd_ptr      = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d         = req_i.func;
          data_d         = req_i.data;
          res_d.status   = sai_pkg::ST_OK;
          res_d.value    = '0;
          res_d.position = '0;
          res_d.count    = 7'(cnt_q);
          res_d.last     = 1'b1;
          unique case (req_i.func)
            sai_pkg::OP_INSERT: begin
              if (full) begin
                res_d.status = sai_pkg::ST_OVERFLOW;
                res_valid_d  = 1'b1;
              end else begin
                ptr_d   = cnt_q;
                idx_d   = ins_idx;
                state_d = (cnt_q > ins_idx) ? S_SHRD : S_FIN;
              end
            end
            sai_pkg::OP_UPDATE: begin
              res_valid_d = 1'b1;
              if (fits) begin
                we    = 1'b1;
                waddr = req_i.index[AW-1:0];
                wdata = req_i.data;
              end else begin
                res_d.status = sai_pkg::ST_BADINDEX;
              end
            end
            sai_pkg::OP_DELETE: begin
              if (fits) begin
                ptr_d   = CW'(req_i.index);
                state_d = ((CW'(req_i.index) + 1'b1) < cnt_q) ? S_SHRD : S_FIN;
              end else begin
                res_d.status = sai_pkg::ST_BADINDEX;
                res_valid_d  = 1'b1;
              end
            end
            sai_pkg::OP_READ: begin
              if (cnt_q == '0) begin
                res_d.status = sai_pkg::ST_EMPTY;
                res_valid_d  = 1'b1;
              end else begin
                ptr_d   = '0;
                state_d = S_RDRD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SHRD: begin
        rd_ptr  = is_ins ? ptr_dec : ptr_inc;
        state_d = S_SHWR;
      end
      S_SHWR: begin
        we    = 1'b1;
        wdata = rdata;
        if (is_ins) begin
          ptr_d   = ptr_dec;
          state_d = ((ptr_q - 1'b1) > idx_q) ? S_SHRD : S_FIN;
        end else begin
          ptr_d   = ptr_inc;
          state_d = ((ptr_q + 2'd2) < cnt_q) ? S_SHRD : S_FIN;
        end
      end
      S_FIN: begin
        if (is_ins) begin
          we    = 1'b1;
          waddr = idx_q[AW-1:0];
          cnt_d = cnt_q + 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
        res_d.status   = sai_pkg::ST_OK;
        res_d.value    = '0;
        res_d.position = '0;
        res_d.count    = 7'(cnt_d);
        res_d.last     = 1'b1;
        res_valid_d    = 1'b1;
        state_d        = S_IDLE;
      end
      S_RDRD: begin
        state_d = S_RDEM;
      end
      S_RDEM: begin
        res_d.status   = sai_pkg::ST_OK;
        res_d.value    = rdata;
        res_d.position = 6'(ptr_q);
        res_d.count    = 7'(cnt_q);
        res_d.last     = (ptr_inc == cnt_q);
        res_valid_d    = 1'b1;
        ptr_d          = ptr_inc;
        state_d        = (ptr_inc == cnt_q) ? S_IDLE : S_RDRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_q       <= sai_pkg::CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cap_q       <= cap_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    idx_q  <= idx_d;
    func_q <= func_d;
    data_q <= data_d;
    res_q  <= res_d;
  end

  sai_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (rdata)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/sai_checker.sv
// Port-level checks of the shifting list block, bound to its top level.
// Depends on sai_pkg and shifting_array_insert_delete_macros.svh.
`include "shifting_array_insert_delete_macros.svh"

module sai_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy_o,
  input logic          res_valid_o,
  input sai_pkg::res_t res_o
);

  `SAI_ASSERT(a_err_single, clk_i, rst_ni, (res_valid_o && res_o.status != sai_pkg::ST_OK) |-> (res_o.last && res_o.value == 0 && res_o.position == 0), "Error item is not a single result.")
  `SAI_ASSERT(a_empty_cnt, clk_i, rst_ni, (res_valid_o && res_o.status == sai_pkg::ST_EMPTY) |-> (res_o.count == 0), "Empty status with nonzero count.")
  `SAI_ASSERT(a_read_busy, clk_i, rst_ni, (res_valid_o && !res_o.last) |-> busy_o, "Read stream stopped before its last item.")
  `SAI_ASSERT_RST(a_reset_quiet, clk_i, (!rst_ni) |-> (!res_valid_o && !busy_o), "Activity during reset.")

endmodule

bind shifting_array_insert_delete sai_checker u_sai_checker (.*);
